@@ src/ntc_pkg.sv @@
// Package: shared types, constants and the thermistor table for the NTC conditioner.
package ntc_pkg;

   localparam int unsigned ADC_W = 12;
   localparam int unsigned TEMP_W = 11;
   localparam int unsigned TABLE_LEN = 100;
   localparam int unsigned IDX_W = 7;
   localparam int unsigned WINDOW_DEPTH_DEF = 10;
   localparam int unsigned TEMP_MASK_W = TEMP_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_SPAN,
      ST_DIV,
      ST_STORE,
      ST_SCAN,
      ST_SETUP,
      ST_MEAN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_sample;
      logic search_start;
      logic search_step;
      logic fetch;
      logic span_setup;
      logic div_step;
      logic store;
      logic scan_start;
      logic scan_step;
      logic mean_setup;
      logic mean_step;
      logic load_out;
   } cmd_type;

   // Status from the datapath back to the controller
   typedef struct packed {
      logic search_done;
      logic div_done;
      logic scan_done;
      logic mean_done;
      logic few_samples;
   } status_type;

   function automatic logic [ADC_W-1:0] ntc_entry(input logic [IDX_W-1:0] idx);
      logic [ADC_W-1:0] v;
      unique case (idx)
         7'd0: v = 12'd3123;  7'd1: v = 12'd3089;  7'd2: v = 12'd3051;
         7'd3: v = 12'd3013;  7'd4: v = 12'd2973;  7'd5: v = 12'd2933;
         7'd6: v = 12'd2893;  7'd7: v = 12'd2852;  7'd8: v = 12'd2810;
         7'd9: v = 12'd2767;  7'd10: v = 12'd2720; 7'd11: v = 12'd2681;
         7'd12: v = 12'd2637; 7'd13: v = 12'd2593; 7'd14: v = 12'd2548;
         7'd15: v = 12'd2503; 7'd16: v = 12'd2458; 7'd17: v = 12'd2412;
         7'd18: v = 12'd2367; 7'd19: v = 12'd2321; 7'd20: v = 12'd2275;
         7'd21: v = 12'd2230; 7'd22: v = 12'd2184; 7'd23: v = 12'd2138;
         7'd24: v = 12'd2093; 7'd25: v = 12'd2048; 7'd26: v = 12'd2002;
         7'd27: v = 12'd1958; 7'd28: v = 12'd1913; 7'd29: v = 12'd1869;
         7'd30: v = 12'd1825; 7'd31: v = 12'd1782; 7'd32: v = 12'd1739;
         7'd33: v = 12'd1697; 7'd34: v = 12'd1655; 7'd35: v = 12'd1614;
         7'd36: v = 12'd1573; 7'd37: v = 12'd1533; 7'd38: v = 12'd1494;
         7'd39: v = 12'd1455; 7'd40: v = 12'd1417; 7'd41: v = 12'd1380;
         7'd42: v = 12'd1343; 7'd43: v = 12'd1307; 7'd44: v = 12'd1272;
         7'd45: v = 12'd1237; 7'd46: v = 12'd1203; 7'd47: v = 12'd1170;
         7'd48: v = 12'd1138; 7'd49: v = 12'd1106; 7'd50: v = 12'd1081;
         7'd51: v = 12'd1045; 7'd52: v = 12'd1016; 7'd53: v = 12'd987;
         7'd54: v = 12'd959;  7'd55: v = 12'd932;  7'd56: v = 12'd905;
         7'd57: v = 12'd879;  7'd58: v = 12'd854;  7'd59: v = 12'd829;
         7'd60: v = 12'd806;  7'd61: v = 12'd782;  7'd62: v = 12'd760;
         7'd63: v = 12'd738;  7'd64: v = 12'd716;  7'd65: v = 12'd696;
         7'd66: v = 12'd675;  7'd67: v = 12'd656;  7'd68: v = 12'd637;
         7'd69: v = 12'd618;  7'd70: v = 12'd600;  7'd71: v = 12'd583;
         7'd72: v = 12'd566;  7'd73: v = 12'd550;  7'd74: v = 12'd534;
         7'd75: v = 12'd518;  7'd76: v = 12'd503;  7'd77: v = 12'd489;
         7'd78: v = 12'd475;  7'd79: v = 12'd461;  7'd80: v = 12'd448;
         7'd81: v = 12'd435;  7'd82: v = 12'd422;  7'd83: v = 12'd410;
         7'd84: v = 12'd398;  7'd85: v = 12'd387;  7'd86: v = 12'd376;
         7'd87: v = 12'd365;  7'd88: v = 12'd355;  7'd89: v = 12'd345;
         7'd90: v = 12'd335;  7'd91: v = 12'd326;  7'd92: v = 12'd316;
         7'd93: v = 12'd308;  7'd94: v = 12'd299;  7'd95: v = 12'd290;
         7'd96: v = 12'd283;  7'd97: v = 12'd274;  7'd98: v = 12'd267;
         7'd99: v = 12'd259;
         default: v = 12'd259;
      endcase
      return v;
   endfunction

endpackage

@@ src/ntc_temperature_conditioner.sv @@
// Top level: NTC thermistor reading to filtered temperature in tenths of a degree.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_adc_sample[11:0]
//   rsp     | out       | rsp_valid/rsp_stall | rsp_temp_tenths[10:0]
//
// One request at a time, each taken through these steps in order:
// 6 or 7 binary-search steps, 9 interpolation divide steps, a window scan of
// sample-count slots and 11 mean divide steps, each divider a shift-subtract loop.
// With fewer than three stored samples the scan and mean are skipped.
// Reset clears the controller, ring slot and sample count; the window needs no clearing.
// A stalled response holds in its register while the next request is worked on.
module ntc_temperature_conditioner #(
   parameter int unsigned WINDOW_DEPTH = ntc_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ntc_pkg::ADC_W-1:0]  req_adc_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ntc_pkg::TEMP_W-1:0] rsp_temp_tenths
);
   import ntc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ntc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ntc_dpath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_adc_sample  (req_adc_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_temp_tenths (rsp_temp_tenths)
   );

endmodule

@@ src/ntc_ctrl.sv @@
// Controller: sequences search, interpolation, window scan and mean per request.
module ntc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  ntc_pkg::status_type status,
   output ntc_pkg::cmd_type    cmd
);
   import ntc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_sample  = 1'b1;
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_FETCH;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SPAN;
         end
         ST_SPAN: begin
            cmd.span_setup = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_STORE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.few_samples) begin
               state_in = ST_OUT;
            end else if (!status.scan_done) begin
               cmd.scan_step = 1'b1;
            end else begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.mean_setup = 1'b1;
            state_in       = ST_MEAN;
         end
         ST_MEAN: begin
            if (status.mean_done) begin
               state_in = ST_OUT;
            end else begin
               cmd.mean_step = 1'b1;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_STORE) begin
         cmd.scan_start = 1'b1;
      end
   end

endmodule

@@ src/ntc_dpath.sv @@
// Datapath: table search, interpolation divider, window store and mean divider.
module ntc_dpath #(
   parameter int unsigned WINDOW_DEPTH = ntc_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ntc_pkg::ADC_W-1:0]   req_adc_sample,
   input  ntc_pkg::cmd_type            cmd,
   output ntc_pkg::status_type         status,
   output logic [ntc_pkg::TEMP_W-1:0]  rsp_temp_tenths
);
   import ntc_pkg::*;

   localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W  = TEMP_W + CNT_W;
   localparam int unsigned DIV_BITS = 9;      // extrapolation below the last entry reaches 333
   localparam int unsigned MDIV_BITS = TEMP_W;

   // sample and search
   logic [ADC_W-1:0]  sample_ff;
   logic signed [IDX_W+1:0] lo_ff, hi_ff;
   logic [IDX_W-1:0]  found_ff;
   logic [IDX_W:0]    mid;
   logic [ADC_W-1:0]  mid_val;
   logic [ADC_W-1:0]  upper_ff, lower_ff;

   // interpolation division
   logic [ADC_W+3:0]  rem_ff;
   logic [ADC_W-1:0]  span_ff;
   logic [DIV_BITS-1:0] quo_ff;
   logic [3:0]        dcnt_ff;
   logic              zero_idx_ff;
   logic [TEMP_W-1:0] temp_val;

   // window
   logic [TEMP_W-1:0] window_mem [WINDOW_DEPTH];
   logic [SLOT_W-1:0] write_slot_ff;
   logic [CNT_W-1:0]  sample_count_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [TEMP_W-1:0] rd_ff;
   logic              rd_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [TEMP_W-1:0] min_ff, max_ff;
   logic [TEMP_W-1:0] first_ff;

   // mean division
   logic [SUM_W-1:0]  num_ff;
   logic [CNT_W-1:0]  den_ff;
   logic [SUM_W:0]    mrem_ff;
   logic [MDIV_BITS-1:0] mquo_ff;
   logic [3:0]        mcnt_ff;

   logic [TEMP_W-1:0] out_ff;

   assign mid     = IDX_W'(0) + (IDX_W+1)'((lo_ff + hi_ff) >>> 1);
   assign mid_val = ntc_entry(mid[IDX_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_adc_sample;
      end
      if (cmd.search_start) begin
         lo_ff    <= '0;
         hi_ff    <= (IDX_W+2)'(TABLE_LEN - 1);
         found_ff <= IDX_W'(TABLE_LEN - 1);
      end else if (cmd.search_step) begin
         if (sample_ff >= mid_val) begin
            found_ff <= mid[IDX_W-1:0];
            hi_ff    <= $signed({1'b0, mid}) - (IDX_W+2)'(1);
         end else begin
            lo_ff <= $signed({1'b0, mid}) + (IDX_W+2)'(1);
         end
      end
      if (cmd.fetch) begin
         zero_idx_ff <= (found_ff == '0);
         upper_ff    <= ntc_entry(found_ff - 1'b1);
         lower_ff    <= ntc_entry(found_ff);
      end
      if (cmd.span_setup) begin
         // above*10 = above*8 + above*2
         rem_ff  <= ({4'd0, upper_ff - sample_ff} << 3) + ({4'd0, upper_ff - sample_ff} << 1);
         span_ff <= upper_ff - lower_ff;
         quo_ff  <= '0;
         dcnt_ff <= 4'(DIV_BITS);
      end else if (cmd.div_step) begin
         // restoring division, one quotient bit per cycle
         if (rem_ff >= ({4'd0, span_ff} << (dcnt_ff - 4'd1))) begin
            rem_ff <= rem_ff - ({4'd0, span_ff} << (dcnt_ff - 4'd1));
            quo_ff <= quo_ff | DIV_BITS'(1 << (dcnt_ff - 4'd1));
         end
         dcnt_ff <= dcnt_ff - 4'd1;
      end
   end

   always_comb begin
      if (zero_idx_ff) begin
         temp_val = '0;
      end else begin
         temp_val = TEMP_W'((found_ff - 1'b1) * 10) + TEMP_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         window_mem[write_slot_ff] <= temp_val;
      end
      rd_ff <= window_mem[scan_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff   <= '0;
         sample_count_ff <= '0;
      end else if (cmd.store) begin
         write_slot_ff <= (write_slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                      : write_slot_ff + 1'b1;
         if (sample_count_ff != CNT_W'(WINDOW_DEPTH)) begin
            sample_count_ff <= sample_count_ff + 1'b1;
         end
         if (sample_count_ff == '0) begin
            first_ff <= temp_val;
         end
      end
   end

   // scan: read one slot per cycle, accumulate it in the cycle after
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         sum_ff      <= '0;
         min_ff      <= '1;
         max_ff      <= '0;
      end else if (cmd.scan_step) begin
         rd_valid_ff <= (scan_ff < sample_count_ff);
         if (scan_ff < sample_count_ff) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_ff);
            if (rd_ff < min_ff) min_ff <= rd_ff;
            if (rd_ff > max_ff) max_ff <= rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mean_setup) begin
         num_ff  <= sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff);
         den_ff  <= sample_count_ff - CNT_W'(2);
         // preload the high numerator bits; they stay below the divisor
         // because the mean fits in TEMP_W bits
         mrem_ff <= (SUM_W+1)'((sum_ff - SUM_W'(min_ff) - SUM_W'(max_ff)) >> TEMP_W);
         mquo_ff <= '0;
         mcnt_ff <= 4'(MDIV_BITS);
      end else if (cmd.mean_step) begin
         // shift-subtract over the low TEMP_W numerator bits
         if ({mrem_ff[SUM_W-1:0], num_ff[mcnt_ff - 4'd1]} >= (SUM_W+1)'(den_ff)) begin
            mrem_ff <= {mrem_ff[SUM_W-1:0], num_ff[mcnt_ff - 4'd1]} - (SUM_W+1)'(den_ff);
            mquo_ff[mcnt_ff - 4'd1] <= 1'b1;
         end else begin
            mrem_ff <= {mrem_ff[SUM_W-1:0], num_ff[mcnt_ff - 4'd1]};
         end
         mcnt_ff <= mcnt_ff - 4'd1;
      end
      if (cmd.load_out) begin
         out_ff <= status.few_samples ? first_ff : mquo_ff;
      end
   end

   assign status.search_done = (lo_ff > hi_ff);
   assign status.div_done    = (dcnt_ff == '0);
   assign status.scan_done   = (scan_ff == sample_count_ff) && !rd_valid_ff;
   assign status.mean_done   = (mcnt_ff == '0);
   assign status.few_samples = (sample_count_ff < CNT_W'(3));
   assign rsp_temp_tenths    = out_ff;

endmodule

@@ src/ntc_checker.sv @@
// Checker: port-level properties of the NTC conditioner, bound to the top level.
module ntc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [10:0] rsp_temp_tenths
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_temp_tenths))
      else $error("response changed while stalled");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_temp_tenths <= 11'd1313)
      else $error("temperature out of range");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after request");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
endmodule

bind ntc_temperature_conditioner ntc_checker u_ntc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_temp_tenths (rsp_temp_tenths)
);

@@ sim/testbench.sv @@
// Testbench: random and directed thermistor readings checked against a built-in conditioner model.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ntc_pkg::*;

   localparam int unsigned DEPTH = WINDOW_DEPTH_DEF;
   localparam int unsigned STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ADC_W-1:0] req_adc_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [TEMP_W-1:0] rsp_temp_tenths;

   ntc_temperature_conditioner #(.WINDOW_DEPTH(DEPTH)) dut (.*);

   always #10 clock = ~clock;

   logic [ADC_W-1:0] readings_q[$];
   int unsigned hold_q[$];          // 0 = normal gap, 1 = drain before this request
   logic [TEMP_W-1:0] temps_due_q[$];
   logic [TEMP_W-1:0] win[DEPTH];
   int unsigned slot_nxt = 0, filled = 0;
   int unsigned mismatches = 0, quiet_cycles = 0;
   int unsigned send_wait = 0, recv_wait = 0;
   bit stim_done = 1'b0;

   // Reference table, kept separate from the package.
   localparam int TBL[100] = '{
      3123, 3089, 3051, 3013, 2973, 2933, 2893, 2852, 2810, 2767,
      2720, 2681, 2637, 2593, 2548, 2503, 2458, 2412, 2367, 2321,
      2275, 2230, 2184, 2138, 2093, 2048, 2002, 1958, 1913, 1869,
      1825, 1782, 1739, 1697, 1655, 1614, 1573, 1533, 1494, 1455,
      1417, 1380, 1343, 1307, 1272, 1237, 1203, 1170, 1138, 1106,
      1081, 1045, 1016,  987,  959,  932,  905,  879,  854,  829,
       806,  782,  760,  738,  716,  696,  675,  656,  637,  618,
       600,  583,  566,  550,  534,  518,  503,  489,  475,  461,
       448,  435,  422,  410,  398,  387,  376,  365,  355,  345,
       335,  326,  316,  308,  299,  290,  283,  274,  267,  259};

   function automatic int unsigned reading_to_tenths(int unsigned rd);
      int idx;
      idx = 99;
      for (int i = 0; i < 100; i++) begin
         if (rd >= TBL[i]) begin
            idx = i;
            break;
         end
      end
      if (idx == 0) return 0;
      return ((idx - 1) * 10 + ((TBL[idx-1] - rd) * 10) / (TBL[idx-1] - TBL[idx])) & 11'h7FF;
   endfunction

   function automatic logic [TEMP_W-1:0] filter_temp(logic [ADC_W-1:0] rd);
      int unsigned sum, lo, hi;
      win[slot_nxt] = TEMP_W'(reading_to_tenths(rd));
      slot_nxt = (slot_nxt + 1) % DEPTH;
      if (filled < DEPTH) filled++;
      if (filled < 3) return win[0];
      sum = 0; lo = 32'hFFFF; hi = 0;
      for (int i = 0; i < filled; i++) begin
         sum += win[i];
         if (win[i] < lo) lo = win[i];
         if (win[i] > hi) hi = win[i];
      end
      return TEMP_W'((sum - lo - hi) / (filled - 2));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         temps_due_q.push_back(filter_temp(req_adc_sample));
         void'(readings_q.pop_front());
         void'(hold_q.pop_front());
         req_valid <= 1'b0;
         send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end else if (!req_valid && readings_q.size() > 0) begin
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (hold_q[0] == 0 || temps_due_q.size() == 0) begin
            req_valid <= 1'b1;
            req_adc_sample <= readings_q[0];
         end
      end
   end

   // monitor and response stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (temps_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %0d", rsp_temp_tenths);
            end else begin
               if (rsp_temp_tenths !== temps_due_q[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("temp_tenths mismatch: expected %0d actual %0d",
                              temps_due_q[0], rsp_temp_tenths);
               end
               void'(temps_due_q.pop_front());
            end
            recv_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         end
         if (recv_wait > 0) begin
            rsp_stall <= 1'b1;
            recv_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic add_reading(logic [ADC_W-1:0] rd, int unsigned drain = 0);
      readings_q.push_back(rd);
      hold_q.push_back(drain);
   endtask

   initial begin
      int unsigned sel;
      add_reading(12'd4095); add_reading(12'd0); add_reading(12'd3123);
      add_reading(12'd3124); add_reading(12'd3122); add_reading(12'd259);
      add_reading(12'd258); add_reading(12'd267); add_reading(12'd2048);
      add_reading(12'd2047); add_reading(12'hAAA); add_reading(12'h555);
      add_reading(12'd1081, 1); add_reading(12'd1080); add_reading(12'd1106);
      for (int n = 0; n < 1700; n++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) add_reading(ADC_W'($urandom_range(250, 3130)), n % 400 == 399);
         else if (sel < 8) add_reading(ADC_W'($urandom), 0);
         else add_reading(ADC_W'(TBL[$urandom_range(0, 99)] + $urandom_range(0, 2) - 1), 0);
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (readings_q.size() == 0 && temps_due_q.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && temps_due_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
